// ----- src/fpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types and constants for the file packet deframer.
// ----------------------------------------------------------------------------
package fpd_pkg;

  // Header layout. The header is sixteen bytes long.
  localparam int unsigned HDR_IDX_W = 5;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN      = 5'd16;
  localparam logic [HDR_IDX_W-1:0] OFS_VERSION  = 5'd4;
  localparam logic [HDR_IDX_W-1:0] OFS_TYPE     = 5'd5;
  localparam logic [HDR_IDX_W-1:0] OFS_PAY_LEN  = 5'd8;
  localparam logic [HDR_IDX_W-1:0] OFS_LAST_HDR = 5'd15;

  localparam logic [7:0] VERSION_OK = 8'd1;

  // Magic bytes in arrival order.
  localparam logic [3:0][7:0] MAGIC = {8'h46, 8'h56, 8'h41, 8'h55};

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_SURPLUS = 2'd3
  } fpd_kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TRUNC   = 3'd4
  } fpd_status_t;

  // One tagged result, as computed by the tracker for the byte in flight.
  typedef struct packed {
    fpd_kind_t   byte_kind;
    logic [7:0]  type_byte;
    logic [15:0] name_length;
    logic [63:0] payload_length;
    fpd_status_t status;
  } fpd_res_t;

endpackage

// ----- src/file_packet_deframer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_packet_deframer_core
// Byte-serial deframer that tags header, name, payload and surplus bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  --------+-----------+------------------------------------------------------
//  in_     | sink      | tdata: raw byte; tlast: final byte of the packet
//  out_    | source    | tdata: byte, type, name length, payload length;
//          |           | tuser: byte kind, status; tlast: final byte, status valid
//
//  One beat is accepted per clock when the result side keeps up. A beat lands
//  in the input register when it is accepted and moves on to the result
//  register once that register has room; its result is then valid there.
//  rst_n is synchronous and active low; it clears the valid flags and all
//  parser state, and no clearing pass is needed afterwards.
//  A stall on out_tready holds the result register; the input register still
//  takes one more beat, after which in_tready drops until the result moves.
// ----------------------------------------------------------------------------
module file_packet_deframer_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [7:0] out_byte, [15:8] type byte,
                                  // [31:16] name_length, [95:32] payload_length
  output logic [4:0]  out_tuser,  // [1:0] byte_kind, [4:2] status
  output logic        out_tlast   // done_res
);
  import fpd_pkg::*;

  // Input register: holds the beat that the tracker is looking at.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Result register.
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_byte_r;
  fpd_res_t   out_res_r;
  logic       out_last_r;

  fpd_res_t   res;
  logic       out_room;
  logic       adv;

  // The byte in the input register moves on whenever the result register is
  // empty or is being emptied in this same cycle.
  assign out_room  = !out_vld_r || out_tready;
  assign adv       = in_vld_r && out_room;
  assign in_tready = !in_vld_r || adv;

  assign in_vld_nxt  = (in_tvalid && in_tready) ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= in_byte_r;
      out_res_r  <= res;
      out_last_r <= in_last_r;
    end
  end

  // Header parser and body counters; they step once per consumed beat.
  fpd_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .res     (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_res_r.payload_length, out_res_r.name_length,
                       out_res_r.type_byte, out_byte_r};
  assign out_tuser  = {out_res_r.status, out_res_r.byte_kind};
  assign out_tlast  = out_last_r;

  // A status other than ok only appears on the final beat of a packet.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.status != ST_OK)) |-> out_last_r)
    else $error("error status on a beat that is not the last");

  // A tagged body byte means the header was complete, so it cannot be short.
  a_body_not_short: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.byte_kind != KIND_HEADER)) |-> (out_res_r.status != ST_SHORT))
    else $error("short header reported on a body byte");

  // Surplus bytes only come once name and payload are done.
  a_surplus_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.byte_kind == KIND_SURPLUS)) |-> (out_res_r.status != ST_TRUNC))
    else $error("truncation reported on a surplus byte");

  // A waiting input beat is neither dropped nor overwritten.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("input register lost a waiting beat");

endmodule

// ----- src/fpd_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_tracker
// Header parser and body counters; tags one byte per advance.
// ----------------------------------------------------------------------------
module fpd_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,       // the byte below is consumed this cycle
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output fpd_pkg::fpd_res_t res
);
  import fpd_pkg::*;

  logic [HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic                 magic_bad_r, magic_bad_nxt;
  logic                 ver_bad_r, ver_bad_nxt;
  logic [7:0]           type_r, type_nxt;
  logic [15:0]          name_len_r, name_len_nxt;
  logic [63:0]          pay_len_r, pay_len_nxt;
  logic [15:0]          name_rem_r, name_rem_nxt;
  logic [63:0]          pay_rem_r, pay_rem_nxt;
  fpd_kind_t            kind;
  fpd_status_t          status;

  always_comb begin
    hdr_idx_nxt   = hdr_idx_r;
    magic_bad_nxt = magic_bad_r;
    ver_bad_nxt   = ver_bad_r;
    type_nxt      = type_r;
    name_len_nxt  = name_len_r;
    pay_len_nxt   = pay_len_r;
    name_rem_nxt  = name_rem_r;
    pay_rem_nxt   = pay_rem_r;
    kind          = KIND_HEADER;

    if (hdr_idx_r < HDR_LEN) begin
      if (hdr_idx_r < OFS_VERSION) begin
        if (in_byte != MAGIC[hdr_idx_r[1:0]]) magic_bad_nxt = 1'b1;
      end else if (hdr_idx_r == OFS_VERSION) begin
        if (in_byte != VERSION_OK) ver_bad_nxt = 1'b1;
      end else if (hdr_idx_r == OFS_TYPE) begin
        type_nxt = in_byte;
      end else if (hdr_idx_r < OFS_PAY_LEN) begin
        name_len_nxt = {name_len_r[7:0], in_byte};
      end else begin
        pay_len_nxt = {pay_len_r[55:0], in_byte};
      end
      hdr_idx_nxt = hdr_idx_r + 5'd1;
      // The final header byte arms both body counters.
      if (hdr_idx_r == OFS_LAST_HDR) begin
        name_rem_nxt = name_len_r;
        pay_rem_nxt  = pay_len_nxt;
      end
    end else if (name_rem_r != 16'd0) begin
      kind         = KIND_NAME;
      name_rem_nxt = name_rem_r - 16'd1;
    end else if (pay_rem_r != 64'd0) begin
      kind        = KIND_PAYLOAD;
      pay_rem_nxt = pay_rem_r - 64'd1;
    end else begin
      kind = KIND_SURPLUS;
    end

    // Status is checked in priority order, and only on the final byte.
    if (!in_last) begin
      status = ST_OK;
    end else if (hdr_idx_nxt < HDR_LEN) begin
      status = ST_SHORT;
    end else if (magic_bad_nxt) begin
      status = ST_MAGIC;
    end else if (ver_bad_nxt) begin
      status = ST_VERSION;
    end else if ((name_rem_nxt != 16'd0) || (pay_rem_nxt != 64'd0)) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end
  end

  assign res.byte_kind      = kind;
  assign res.type_byte      = type_nxt;
  assign res.name_length    = name_len_nxt;
  assign res.payload_length = pay_len_nxt;
  assign res.status         = status;

  // The last byte of a packet returns every field to its idle value.
  always_ff @(posedge clk) begin
    if (!rst_n || (adv && in_last)) begin
      hdr_idx_r   <= '0;
      magic_bad_r <= 1'b0;
      ver_bad_r   <= 1'b0;
      type_r      <= '0;
      name_len_r  <= '0;
      pay_len_r   <= '0;
      name_rem_r  <= '0;
      pay_rem_r   <= '0;
    end else if (adv) begin
      hdr_idx_r   <= hdr_idx_nxt;
      magic_bad_r <= magic_bad_nxt;
      ver_bad_r   <= ver_bad_nxt;
      type_r      <= type_nxt;
      name_len_r  <= name_len_nxt;
      pay_len_r   <= pay_len_nxt;
      name_rem_r  <= name_rem_nxt;
      pay_rem_r   <= pay_rem_nxt;
    end
  end

  // Once the header is complete, the index parks at the header length.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r <= HDR_LEN)
    else $error("header index ran past the header length");

  // Body counters stay clear until the final header byte has arrived.
  a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_idx_r < HDR_LEN) |-> ((name_rem_r == 16'd0) && (pay_rem_r == 64'd0)))
    else $error("body counter loaded before the header was complete");

  // A name byte is only tagged while name bytes are still owed.
  a_name_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !in_last && (kind == KIND_NAME)) |=> (name_rem_r == $past(name_rem_r) - 16'd1))
    else $error("name counter did not step on a name byte");

endmodule

// ----- sim/fpd_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_stream_checker
// Watches both streams of the deframer, tracks the header itself and compares
// every result beat, field by field, with the oldest predicted tag.
// ----------------------------------------------------------------------------
module fpd_stream_checker (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,

  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic [4:0]  out_tuser,
  input  logic        out_tlast,

  output int          fail_count,
  output int          pending,
  output int          beats_seen,
  output int          frames_ok,
  output int          frames_bad
);
  import fpd_pkg::*;

  // One predicted result beat.
  typedef struct packed {
    logic [7:0]  data;
    fpd_kind_t   kind;
    logic [7:0]  ftype;
    logic [15:0] nlen;
    logic [63:0] plen;
    logic        last;
    fpd_status_t status;
  } fpd_tag_t;

  fpd_tag_t predicted_tags[$];
  fpd_tag_t head_tag;

  // Private copy of the parser state.
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic                 magic_err;
  logic                 version_err;
  logic [7:0]           ftype_q;
  logic [15:0]          nlen_q;
  logic [63:0]          plen_q;
  logic [15:0]          name_left;
  logic [63:0]          pay_left;

  function automatic void clear_parser();
    hdr_idx     = '0;
    magic_err   = 1'b0;
    version_err = 1'b0;
    ftype_q     = '0;
    nlen_q      = '0;
    plen_q      = '0;
    name_left   = '0;
    pay_left    = '0;
  endfunction

  // Takes one raw byte and returns the tag the deframer must emit for it.
  function automatic fpd_tag_t track_byte(input logic [7:0] b, input logic last);
    fpd_tag_t t;
    t.data   = b;
    t.last   = last;
    t.status = ST_OK;
    if (hdr_idx < HDR_LEN) begin
      t.kind = KIND_HEADER;
      if (hdr_idx < OFS_VERSION) begin
        if (b != MAGIC[hdr_idx[1:0]]) magic_err = 1'b1;
      end else if (hdr_idx == OFS_VERSION) begin
        if (b != VERSION_OK) version_err = 1'b1;
      end else if (hdr_idx == OFS_TYPE) begin
        ftype_q = b;
      end else if (hdr_idx < OFS_PAY_LEN) begin
        nlen_q = {nlen_q[7:0], b};
      end else begin
        plen_q = {plen_q[55:0], b};
      end
      hdr_idx = hdr_idx + 1'b1;
      if (hdr_idx == HDR_LEN) begin
        name_left = nlen_q;
        pay_left  = plen_q;
      end
    end else if (name_left != 0) begin
      t.kind    = KIND_NAME;
      name_left = name_left - 1'b1;
    end else if (pay_left != 0) begin
      t.kind   = KIND_PAYLOAD;
      pay_left = pay_left - 1'b1;
    end else begin
      t.kind = KIND_SURPLUS;
    end

    if (last) begin
      if (hdr_idx < HDR_LEN)                   t.status = ST_SHORT;
      else if (magic_err)                      t.status = ST_MAGIC;
      else if (version_err)                    t.status = ST_VERSION;
      else if (name_left != 0 || pay_left != 0) t.status = ST_TRUNC;
      else                                     t.status = ST_OK;
    end

    t.ftype = ftype_q;
    t.nlen  = nlen_q;
    t.plen  = plen_q;
    if (last) clear_parser();
    return t;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    beats_seen = 0;
    frames_ok  = 0;
    frames_bad = 0;
    pending    = 0;
    clear_parser();
  end

  // Compare first, then predict, so a beat taken in at this edge can never
  // be matched against a result leaving at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      predicted_tags.delete();
      clear_parser();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        beats_seen++;
        if (predicted_tags.size() == 0) begin
          fail_count++;
          $display("%0t ns: result beat with nothing predicted, expected none, actual %0h/%0h",
                    $time, out_tdata, out_tuser);
        end else begin
          head_tag = predicted_tags.pop_front();
          check_field("out_byte",       head_tag.data,   out_tdata[7:0]);
          check_field("type byte",      head_tag.ftype,  out_tdata[15:8]);
          check_field("name_length",    head_tag.nlen,   out_tdata[31:16]);
          check_field("payload_length", head_tag.plen,   out_tdata[95:32]);
          check_field("byte_kind",      head_tag.kind,   out_tuser[1:0]);
          check_field("status",         head_tag.status, out_tuser[4:2]);
          check_field("done",           head_tag.last,   out_tlast);
          if (head_tag.last) begin
            if (head_tag.status == ST_OK) frames_ok++;
            else frames_bad++;
          end
        end
      end
      if (in_tvalid && in_tready)
        predicted_tags.insert(predicted_tags.size(), track_byte(in_tdata, in_tlast));
      pending <= predicted_tags.size();
    end
  end

endmodule

// ----- sim/file_packet_deframer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_packet_deframer_core_tb
// Drives the deframer with a stream of file packets, about half well-formed,
// plus short, corrupted and truncated ones, under random input gaps and output
// stalls, and leaves the prediction and checking to fpd_stream_checker.
// ----------------------------------------------------------------------------
module file_packet_deframer_core_tb;
  import fpd_pkg::*;

  // Length of the one long receiver hold-off, in clock cycles. It is far
  // longer than the two beats the block can buffer, so the input must stall.
  localparam int HOLD_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;   // in_last
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // [7:0] out_byte, [15:8] type byte,
                           // [31:16] name_length, [95:32] payload_length
  logic [4:0]  out_tuser;  // [1:0] byte_kind, [4:2] status
  logic        out_tlast;  // done_res

  int fail_count;
  int pending;
  int beats_seen;
  int frames_ok;
  int frames_bad;

  // Raw packet bytes, queued up front and then streamed by the sender.
  logic [7:0] stim_bytes[$];
  bit         stim_last[$];
  bit         sender_done;
  bit         held_off;
  int         packet_count;

  file_packet_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  fpd_stream_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .beats_seen (beats_seen),
    .frames_ok  (frames_ok),
    .frames_bad (frames_bad)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Queues one packet. Only the first hdr_cut header bytes are sent when
  // hdr_cut is below sixteen; otherwise the full header goes out followed by
  // body_cnt random bytes. The final byte carries the last flag.
  task automatic add_frame(input int hdr_cut, input bit bad_magic, input bit bad_version,
                           input logic [7:0] ftype, input logic [15:0] nlen,
                           input logic [63:0] plen, input int body_cnt);
    logic [7:0] hdr[16];
    int total;
    int k;
    for (k = 0; k < 4; k++) hdr[k] = MAGIC[k];
    // A corrupted magic byte is flipped in at least one bit.
    if (bad_magic) hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    hdr[4] = bad_version ? (VERSION_OK ^ 8'($urandom_range(1, 255))) : VERSION_OK;
    hdr[5] = ftype;
    hdr[6] = nlen[15:8];
    hdr[7] = nlen[7:0];
    for (k = 0; k < 8; k++) hdr[8 + k] = plen[63 - 8*k -: 8];
    total = (hdr_cut < 16) ? hdr_cut : 16 + body_cnt;
    for (k = 0; k < total; k++) begin
      stim_bytes.insert(stim_bytes.size(),
                        (k < 16) ? hdr[k] : 8'($urandom_range(0, 255)));
      stim_last.insert(stim_last.size(), k == total - 1);
    end
    packet_count++;
  endtask

  // Picks one packet shape at random. Lengths stay small so that most
  // packets complete; huge lengths appear only in packets that end early.
  task automatic add_random_frame();
    int pick;
    int n;
    int p;
    logic [7:0] ftype;
    pick  = $urandom_range(0, 99);
    n     = $urandom_range(0, 5);
    p     = $urandom_range(0, 24);
    ftype = 8'($urandom_range(0, 255));
    if (pick < 50) begin
      // Well-formed, sometimes with a few surplus bytes at the end.
      add_frame(16, 1'b0, 1'b0, ftype, 16'(n), 64'(p),
                n + p + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0));
    end else if (pick < 62) begin
      // Body ends before all name and payload bytes arrived.
      if (n + p == 0) p = 1;
      add_frame(16, 1'b0, 1'b0, ftype, 16'(n), 64'(p), $urandom_range(0, n + p - 1));
    end else if (pick < 70) begin
      // Last flag inside the header; header errors must not win over it.
      add_frame($urandom_range(1, 15), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                ftype, 16'($urandom_range(0, 65535)), {$urandom, $urandom}, 0);
    end else if (pick < 78) begin
      add_frame(16, 1'b1, 1'b0, ftype, 16'(n), 64'(p), n + p);
    end else if (pick < 86) begin
      add_frame(16, 1'b0, 1'b1, ftype, 16'(n), 64'(p), n + p);
    end else if (pick < 93) begin
      // Huge lengths: every length bit gets exercised, body always short.
      add_frame(16, 1'b0, 1'b0, ftype, 16'($urandom_range(0, 65535)),
                {$urandom, $urandom}, $urandom_range(0, 20));
    end else begin
      // Both header errors, often with a short body as well.
      add_frame(16, 1'b1, 1'b1, ftype, 16'(n), 64'(p), $urandom_range(0, n + p));
    end
  endtask

  // Reset is asserted once, at the start, and then released.
  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: streams the queued bytes in bursts of random length, with random
  // gaps between bursts and some bursts back to back. Valid stays high
  // through a burst, and a byte advances only on an accepted beat.
  initial begin : byte_source
    int pos;
    int burst;
    int gap;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tlast     <= 1'b0;
    sender_done  = 1'b0;
    packet_count = 0;

    // Directed opening: a one-byte packet that ends inside the header, then
    // a good packet with one name byte, one payload byte and one surplus byte,
    // so all four byte kinds and the ok status show up early.
    add_frame(1, 1'b0, 1'b0, 8'h00, 16'h0000, 64'h0, 0);
    add_frame(16, 1'b0, 1'b0, 8'hFF, 16'h0001, 64'h1, 3);
    while (stim_bytes.size() < 1000) add_random_frame();

    while (rst_n !== 1'b1) @(posedge clk);
    pos = 0;
    while (pos < stim_bytes.size()) begin
      burst = $urandom_range(1, 48);
      while (burst != 0 && pos < stim_bytes.size()) begin
        in_tvalid <= 1'b1;
        in_tdata  <= stim_bytes[pos];
        in_tlast  <= stim_last[pos];
        @(posedge clk);
        if (in_tready) begin
          pos++;
          burst--;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid   <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: segments of random length, each fully ready, randomly ready,
  // or ready with a periodic stall. Once enough results have passed, it
  // holds off for a long stretch while the sender keeps offering bytes.
  initial begin : result_sink
    int seg;
    int mode;
    int k;
    out_tready <= 1'b0;
    held_off   = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && beats_seen >= 200) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(8, 64);
        for (k = 0; k < seg; k++) begin
          case (mode)
            0: begin
              out_tready <= 1'b1;
            end
            1: begin
              out_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_tready <= ((k % 4) != 3);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // End of run: once every byte is in and no result is outstanding, wait for
  // any stray beat to show up, then give the verdict.
  initial begin : verdict
    while (!sender_done) @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Streamed %0d packets as %0d bytes; %0d result beats checked.",
             packet_count, stim_bytes.size(), beats_seen);
    $display("Packets ending ok: %0d, ending with an error status: %0d.",
             frames_ok, frames_bad);
    if (fail_count == 0) begin
      $display("file_packet_deframer_core: match");
    end else begin
      $display("file_packet_deframer_core: mismatch");
    end
    $finish;
  end

  // Watchdog, set far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #5ms;
    $display("Run timed out with %0d results still outstanding.", pending);
    $display("file_packet_deframer_core: mismatch");
    $finish;
  end

endmodule
